// ===== hw/rtl/ews_pkg.sv =====
// Package for entropy_width_select: constants, types and the log2 table function.
// Used by every module of the block; depends on nothing.
`default_nettype none
package ews_pkg;
    localparam int MaxCandidatesDef = 64;
    localparam int LogTableBitsDef = 8;
    localparam int WeightW = 24;
    localparam int StoreW = 23;
    localparam int RegW = 10;
    localparam int HnW = 16;

    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StRange = 2'd1;
    localparam logic [1:0] StInvalid = 2'd2;
    localparam logic [1:0] StZero = 2'd3;

    localparam logic RegWidthMin = 1'b0;
    localparam logic RegWidthMax = 1'b1;

    typedef enum logic [2:0] {
        BK_IDLE, BK_DIV, BK_TERM, BK_ACC, BK_NORM, BK_MAP, BK_OUT
    } back_state_t;

    function automatic logic [15:0] log_table(input logic [11:0] k, input int bits);
        logic [63:0] x;
        logic [15:0] r;
        x = ({52'd0, 12'd1} << bits) + {52'd0, k};
        x = x << (30 - bits);
        r = '0;
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 30;
            r = {r[14:0], 1'b0};
            if (x >= 64'h8000_0000) begin
                x = x >> 1;
                r[0] = 1'b1;
            end
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/ews_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses ews_pkg; shared by the back end for shares and normalization.
`default_nettype none
module ews_divider
    import ews_pkg::*;
#(
    parameter int NumW = 48,
    parameter int DenW = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            go,
    input  wire logic [NumW-1:0] num,
    input  wire logic [DenW-1:0] den,
    output logic                 done,
    output logic [NumW-1:0]      quot
);
    localparam int CntW = $clog2(NumW + 1);
    logic [NumW-1:0] q_reg, q_next;
    logic [DenW:0] rem_reg, rem_next;
    logic [DenW-1:0] d_reg, d_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [DenW:0] trial;

    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[DenW-1:0], q_reg[NumW-1]};
        if (go)
        begin
            q_next = num;
            rem_next = '0;
            d_next = den;
            cnt_next = CntW'(NumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[NumW-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/ews_front.sv =====
// Front end: accepts weights, stores them, sums the mass and classifies the list.
// Uses ews_pkg; feeds the back end through a one-entry job queue.
`default_nettype none
module ews_front
    import ews_pkg::*;
#(
    parameter int MaxCandidates = MaxCandidatesDef,
    parameter int CountW = $clog2(MaxCandidates + 1),
    parameter int AddrW = $clog2(MaxCandidates),
    parameter int MassW = StoreW + CountW
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire logic [WeightW-1:0] weight,
    input  wire logic               not_finite,
    input  wire logic               last,
    input  wire logic [AddrW-1:0]   rd_addr,
    output logic [StoreW-1:0]       rd_data,
    output logic                    job_valid,
    input  wire logic               job_pop,
    output logic [MassW-1:0]        job_mass,
    output logic [CountW-1:0]       job_count,
    output logic                    job_bad,
    output logic                    job_over
);
    logic [StoreW-1:0] mem [MaxCandidates];
    logic [StoreW-1:0] rd_reg;
    logic [MassW-1:0] mass_reg, mass_next;
    logic [CountW-1:0] count_reg, count_next;
    logic bad_reg, bad_next, over_reg, over_next;
    logic jv_reg, jv_next;
    logic [MassW-1:0] jm_reg, jm_next;
    logic [CountW-1:0] jc_reg, jc_next;
    logic jb_reg, jb_next, jo_reg, jo_next;
    logic neg, room;

    assign neg = weight[WeightW-1];
    assign room = count_reg < CountW'(MaxCandidates);

    always_ff @(posedge clk)
    begin
        if (take && room)
        begin
            mem[count_reg[AddrW-1:0]] <= weight[StoreW-1:0];
        end
        rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        mass_next = mass_reg;
        count_next = count_reg;
        bad_next = bad_reg;
        over_next = over_reg;
        jv_next = jv_reg && !job_pop;
        jm_next = jm_reg;
        jc_next = jc_reg;
        jb_next = jb_reg;
        jo_next = jo_reg;
        if (take)
        begin
            bad_next = bad_reg || not_finite || neg;
            if (room)
            begin
                if (!neg)
                begin
                    mass_next = mass_reg + MassW'(weight[StoreW-1:0]);
                end
                count_next = count_reg + 1'b1;
            end
            else
            begin
                over_next = 1'b1;
            end
            if (last)
            begin
                jv_next = 1'b1;
                jm_next = mass_next;
                jc_next = count_next;
                jb_next = bad_next;
                jo_next = over_next;
                mass_next = '0;
                count_next = '0;
                bad_next = 1'b0;
                over_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mass_reg <= '0;
            count_reg <= '0;
            bad_reg <= 1'b0;
            over_reg <= 1'b0;
            jv_reg <= 1'b0;
        end
        else
        begin
            mass_reg <= mass_next;
            count_reg <= count_next;
            bad_reg <= bad_next;
            over_reg <= over_next;
            jv_reg <= jv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jm_reg <= jm_next;
        jc_reg <= jc_next;
        jb_reg <= jb_next;
        jo_reg <= jo_next;
    end

    assign rd_data = rd_reg;
    assign job_valid = jv_reg;
    assign job_mass = jm_reg;
    assign job_count = jc_reg;
    assign job_bad = jb_reg;
    assign job_over = jo_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/ews_back.sv =====
// Back end: walks the stored weights, sums the entropy terms, normalizes and maps the width.
// Uses ews_pkg and ews_divider.
`default_nettype none
module ews_back
    import ews_pkg::*;
#(
    parameter int MaxCandidates = MaxCandidatesDef,
    parameter int LogTableBits = LogTableBitsDef,
    parameter int CountW = $clog2(MaxCandidates + 1),
    parameter int AddrW = $clog2(MaxCandidates),
    parameter int MassW = StoreW + CountW
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [RegW-1:0]   width_min,
    input  wire logic [RegW-1:0]   width_max,
    input  wire logic              job_valid,
    output logic                   job_pop,
    input  wire logic [MassW-1:0]  job_mass,
    input  wire logic [CountW-1:0] job_count,
    input  wire logic              job_bad,
    input  wire logic              job_over,
    output logic [AddrW-1:0]       rd_addr,
    input  wire logic [StoreW-1:0] rd_data,
    output logic                   done,
    output logic [1:0]             status,
    output logic [RegW-1:0]        tree_width,
    output logic [HnW-1:0]         entropy_q15
);
    localparam int NumW = 48;
    localparam int DenW = MassW;
    localparam int HW = 24;
    localparam int LogW = 22;
    localparam int LogDepth = 1 << LogTableBits;

    back_state_t st_reg, st_next;
    logic [MassW-1:0] mass_reg;
    logic [CountW-1:0] cnt_reg, idx_reg, idx_next;
    logic [HW-1:0] h_reg, h_next;
    logic [33:0] term_reg, term_next;
    logic [RegW-1:0] wmin_reg, wmax_reg;
    logic [1:0] status_reg, status_next;
    logic [RegW-1:0] width_reg, width_next;
    logic [HnW-1:0] hn_reg, hn_next;
    logic [26:0] prod_reg, prod_next;
    logic done_next, done_reg;

    logic div_go, div_done;
    logic [NumW-1:0] div_num, div_q;
    logic [DenW-1:0] div_den;

    logic [15:0] log_rom [LogDepth];

    ews_divider #(.NumW(NumW), .DenW(DenW)) u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
        .done(div_done), .quot(div_q)
    );

    always_comb
    begin
        for (int i = 0; i < LogDepth; i++)
        begin
            log_rom[i] = log_table(12'(i), LogTableBits);
        end
    end

    function automatic logic [16:0] lead_split(input logic [16:0] v);
        logic [4:0] e;
        logic [16:0] r;
        logic [11:0] k;
        e = '0;
        for (int i = 1; i < 17; i++)
        begin
            if (v[i]) e = 5'(i);
        end
        r = v & ~(17'd1 << e);
        if (int'(e) >= LogTableBits) k = 12'(r >> (int'(e) - LogTableBits));
        else k = 12'(r << (LogTableBits - int'(e)));
        return {e, k};
    endfunction

    logic [16:0] p;
    logic [16:0] p_split, c_split;
    logic [LogW-1:0] nl;
    logic [LogW-1:0] lcount;
    assign p = div_q[16:0];
    assign p_split = lead_split(p);
    assign c_split = lead_split(17'(cnt_reg));
    assign nl = LogW'({5'd16, 16'd0}) - LogW'({p_split[16:12], 16'd0})
        - LogW'(log_rom[p_split[LogTableBits-1:0]]);
    assign lcount = LogW'({c_split[16:12], 16'd0})
        + LogW'(log_rom[c_split[LogTableBits-1:0]]);
    assign rd_addr = idx_reg[AddrW-1:0];

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE: if (job_valid) st_next = (status_next != StOk || job_count == CountW'(1))
                ? BK_MAP : BK_DIV;
            BK_DIV: st_next = BK_TERM;
            BK_TERM: if (div_done) st_next = BK_ACC;
            BK_ACC: st_next = (idx_reg == cnt_reg) ? BK_NORM : BK_DIV;
            BK_NORM: if (div_done) st_next = BK_MAP;
            BK_MAP: st_next = BK_OUT;
            BK_OUT: st_next = BK_IDLE;
            default: st_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop = 1'b0;
        div_go = 1'b0;
        div_num = '0;
        div_den = mass_reg;
        idx_next = idx_reg;
        h_next = h_reg;
        term_next = term_reg;
        status_next = status_reg;
        width_next = width_reg;
        hn_next = hn_reg;
        prod_next = prod_reg;
        done_next = 1'b0;
        case (st_reg)
            BK_IDLE:
            begin
                if (width_min == '0 || width_min > width_max || job_over) status_next = StRange;
                else if (job_bad) status_next = StInvalid;
                else if (job_mass == '0) status_next = StZero;
                else status_next = StOk;
                idx_next = '0;
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    h_next = '0;
                    hn_next = '0;
                end
            end
            BK_DIV:
            begin
                div_go = 1'b1;
                div_num = NumW'({rd_data, 16'd0});
                idx_next = idx_reg + 1'b1;
            end
            BK_TERM:
            begin
                term_next = (p == '0) ? '0 : 34'(({17'd0, p} * {12'd0, nl}) >> 16);
            end
            BK_ACC:
            begin
                h_next = h_reg + HW'(term_reg);
                if (idx_reg == cnt_reg)
                begin
                    div_go = 1'b1;
                    div_num = NumW'({h_next, 15'd0});
                    div_den = DenW'(lcount);
                end
            end
            BK_NORM:
            begin
                if (div_done)
                begin
                    hn_next = (div_q > NumW'(32768)) ? HnW'(32768) : div_q[HnW-1:0];
                end
            end
            BK_MAP:
            begin
                prod_next = 27'(wmax_reg - wmin_reg) * 27'(hn_reg) + 27'd16384;
            end
            BK_OUT:
            begin
                done_next = 1'b1;
                width_next = wmin_reg + RegW'(prod_reg >> 15);
                if (width_next > wmax_reg) width_next = wmax_reg;
                if (status_reg != StOk)
                begin
                    width_next = '0;
                    hn_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == BK_IDLE && job_valid)
        begin
            mass_reg <= job_mass;
            cnt_reg <= job_count;
            wmin_reg <= width_min;
            wmax_reg <= width_max;
        end
        idx_reg <= idx_next;
        h_reg <= h_next;
        term_reg <= term_next;
        status_reg <= status_next;
        width_reg <= width_next;
        hn_reg <= hn_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign status = status_reg;
    assign tree_width = width_reg;
    assign entropy_q15 = hn_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/entropy_width_select.sv =====
// Top level of entropy_width_select: configuration registers, front and back ends.
// Uses ews_pkg, ews_front and ews_back.
// Weights are taken one a cycle while busy is low; the word with last set ends a list.
// A list is then finished by the back end, which walks the stored weights with a
// one-bit-per-cycle divider, one division per candidate, then divides once more for
// the normalization and maps the width; busy is high until the result strobe.
// done is held one cycle and cannot be stalled.
`default_nettype none
module entropy_width_select
    import ews_pkg::*;
#(
    parameter int MaxCandidates = MaxCandidatesDef,
    parameter int LogTableBits = LogTableBitsDef
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [WeightW-1:0] weight,
    input  wire logic               not_finite,
    input  wire logic               last,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [RegW-1:0]    cfg_data,
    output logic                    done,
    output logic [1:0]              status,
    output logic [RegW-1:0]         tree_width,
    output logic [HnW-1:0]          entropy_q15
);
    localparam int CountW = $clog2(MaxCandidates + 1);
    localparam int AddrW = $clog2(MaxCandidates);
    localparam int MassW = StoreW + CountW;

    logic [RegW-1:0] wmin_reg, wmax_reg;
    logic take, job_valid, job_pop, job_bad, job_over, list_reg;
    logic [MassW-1:0] job_mass;
    logic [CountW-1:0] job_count;
    logic [AddrW-1:0] rd_addr;
    logic [StoreW-1:0] rd_data;

    assign take = start && !busy;
    assign busy = job_valid || list_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wmin_reg <= RegW'(1);
            wmax_reg <= RegW'(8);
            list_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == RegWidthMin) wmin_reg <= cfg_data;
            if (cfg_we && cfg_index == RegWidthMax) wmax_reg <= cfg_data;
            if (take && last) list_reg <= 1'b1;
            else if (done) list_reg <= 1'b0;
        end
    end

    ews_front #(.MaxCandidates(MaxCandidates)) u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .weight(weight),
        .not_finite(not_finite), .last(last), .rd_addr(rd_addr), .rd_data(rd_data),
        .job_valid(job_valid), .job_pop(job_pop), .job_mass(job_mass),
        .job_count(job_count), .job_bad(job_bad), .job_over(job_over)
    );

    ews_back #(.MaxCandidates(MaxCandidates), .LogTableBits(LogTableBits)) u_back (
        .clk(clk), .rst_n(rst_n), .width_min(wmin_reg), .width_max(wmax_reg),
        .job_valid(job_valid), .job_pop(job_pop), .job_mass(job_mass),
        .job_count(job_count), .job_bad(job_bad), .job_over(job_over),
        .rd_addr(rd_addr), .rd_data(rd_data), .done(done), .status(status),
        .tree_width(tree_width), .entropy_q15(entropy_q15)
    );
endmodule
`default_nettype wire
